[sv/m3i_pkg.sv]
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int unsigned IN_FRAC_BITS  = 12;
  localparam int unsigned OUT_FRAC_BITS = 16;
  localparam int unsigned SCALE         = IN_FRAC_BITS + OUT_FRAC_BITS;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned PROD_W = 2 * IN_W;
  localparam int unsigned COF_W  = PROD_W + 1;
  localparam int unsigned DP_W   = IN_W + COF_W;
  localparam int unsigned DET_W  = DP_W + 2;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned Q_W    = OUT_W + 1;
  localparam int unsigned NUM_W  = COF_W + SCALE;

  // one stage to set up, one per quotient bit, one to saturate
  localparam int unsigned LANE_LAT  = Q_W + 2;
  localparam int unsigned FRONT_LAT = 5;
  localparam int unsigned PIPE_LAT  = FRONT_LAT + LANE_LAT;

  localparam logic [Q_W-1:0] POS_LIM = Q_W'(64'h7FFF_FFFF);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(64'h8000_0000);

  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic signed [IN_W-1:0] m00;
    logic signed [IN_W-1:0] m01;
    logic signed [IN_W-1:0] m02;
    logic signed [IN_W-1:0] m10;
    logic signed [IN_W-1:0] m11;
    logic signed [IN_W-1:0] m12;
    logic signed [IN_W-1:0] m20;
    logic signed [IN_W-1:0] m21;
    logic signed [IN_W-1:0] m22;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic                    singular;
  } res_t;

endpackage

[sv/m3i_front.sv]
`timescale 1ns / 1ps
module m3i_front
  import m3i_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  req_t       req_i,
  output logic       vld_o,
  output cof_t [8:0] cof_o,
  output det_t       det_o
);

  logic                      v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [IN_W-1:0]    a_q [9];
  logic signed [IN_W-1:0]    a2_q [3];
  logic signed [IN_W-1:0]    a3_q [3];
  logic signed [PROD_W-1:0]  pa_d [9];
  logic signed [PROD_W-1:0]  pb_d [9];
  logic signed [PROD_W-1:0]  pa_q [9];
  logic signed [PROD_W-1:0]  pb_q [9];
  cof_t                      cof3_q [9];
  cof_t                      cof4_q [9];
  cof_t                      cof5_q [9];
  logic signed [DP_W-1:0]    dp_q [3];
  det_t                      det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // cofactor product pairs
  always_comb begin
    pa_d[0] = a_q[4] * a_q[8];  pb_d[0] = a_q[5] * a_q[7];
    pa_d[1] = a_q[2] * a_q[7];  pb_d[1] = a_q[1] * a_q[8];
    pa_d[2] = a_q[1] * a_q[5];  pb_d[2] = a_q[2] * a_q[4];
    pa_d[3] = a_q[5] * a_q[6];  pb_d[3] = a_q[3] * a_q[8];
    pa_d[4] = a_q[0] * a_q[8];  pb_d[4] = a_q[2] * a_q[6];
    pa_d[5] = a_q[2] * a_q[3];  pb_d[5] = a_q[0] * a_q[5];
    pa_d[6] = a_q[3] * a_q[7];  pb_d[6] = a_q[4] * a_q[6];
    pa_d[7] = a_q[1] * a_q[6];  pb_d[7] = a_q[0] * a_q[7];
    pa_d[8] = a_q[0] * a_q[4];  pb_d[8] = a_q[1] * a_q[3];
  end

  always_ff @(posedge clk_i) begin
    a_q[0] <= req_i.m00;
    a_q[1] <= req_i.m01;
    a_q[2] <= req_i.m02;
    a_q[3] <= req_i.m10;
    a_q[4] <= req_i.m11;
    a_q[5] <= req_i.m12;
    a_q[6] <= req_i.m20;
    a_q[7] <= req_i.m21;
    a_q[8] <= req_i.m22;
    for (int i = 0; i < 9; i++) begin
      pa_q[i]   <= pa_d[i];
      pb_q[i]   <= pb_d[i];
      cof3_q[i] <= COF_W'(pa_q[i]) - COF_W'(pb_q[i]);
      cof4_q[i] <= cof3_q[i];
      cof5_q[i] <= cof4_q[i];
    end
    for (int j = 0; j < 3; j++) begin
      a2_q[j] <= a_q[j];
      a3_q[j] <= a2_q[j];
    end
    // first row against first adjugate column
    dp_q[0] <= a3_q[0] * cof3_q[0];
    dp_q[1] <= a3_q[1] * cof3_q[3];
    dp_q[2] <= a3_q[2] * cof3_q[6];
    det_q   <= DET_W'(dp_q[0]) + DET_W'(dp_q[1]) + DET_W'(dp_q[2]);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cof_o[i] = cof5_q[i];
    end
  end

  assign vld_o = v5_q;
  assign det_o = det_q;

endmodule

[sv/m3i_lane.sv]
`timescale 1ns / 1ps
module m3i_lane
  import m3i_pkg::*;
(
  input  logic                    clk_i,
  input  cof_t                    cof_i,
  input  det_t                    det_i,
  output logic signed [OUT_W-1:0] res_o
);

  logic [COF_W-1:0] mag;
  logic [DET_W-1:0] dmag;
  logic [NUM_W-1:0] num;
  logic [DET_W-1:0] r_init;

  logic [DET_W-1:0] r_q    [Q_W+1];
  logic [DET_W-1:0] d_q    [Q_W+1];
  logic [Q_W-1:0]   n_q    [Q_W+1];
  logic [Q_W-1:0]   q_q    [Q_W+1];
  logic             neg_q  [Q_W+1];
  logic             ovf_q  [Q_W+1];
  logic             zero_q [Q_W+1];

  logic [Q_W-1:0]   lim;
  logic [Q_W-1:0]   mq;
  logic [Q_W-1:0]   sq;
  logic signed [OUT_W-1:0] res_q;

  always_comb begin
    mag    = cof_i[COF_W-1] ? COF_W'(-cof_i) : COF_W'(cof_i);
    dmag   = det_i[DET_W-1] ? DET_W'(-det_i) : DET_W'(det_i);
    num    = {mag, SCALE'(0)};
    r_init = DET_W'(num[NUM_W-1:Q_W]);
  end

  // setup: upper numerator bits seed the remainder, overflow when they reach the divisor
  always_ff @(posedge clk_i) begin
    r_q[0]    <= r_init;
    d_q[0]    <= dmag;
    n_q[0]    <= num[Q_W-1:0];
    q_q[0]    <= '0;
    neg_q[0]  <= cof_i[COF_W-1] ^ det_i[DET_W-1];
    ovf_q[0]  <= (r_init >= dmag);
    zero_q[0] <= (det_i == '0);
  end

  // one restoring step per quotient bit
  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DET_W:0] rs;
    logic [DET_W:0] diff;
    logic           ge;

    always_comb begin
      rs   = {r_q[k-1], n_q[k-1][Q_W-1]};
      diff = rs - {1'b0, d_q[k-1]};
      ge   = (rs >= {1'b0, d_q[k-1]});
    end

    always_ff @(posedge clk_i) begin
      r_q[k]    <= ge ? diff[DET_W-1:0] : rs[DET_W-1:0];
      d_q[k]    <= d_q[k-1];
      n_q[k]    <= {n_q[k-1][Q_W-2:0], 1'b0};
      q_q[k]    <= {q_q[k-1][Q_W-2:0], ge};
      neg_q[k]  <= neg_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      zero_q[k] <= zero_q[k-1];
    end
  end

  always_comb begin
    lim = neg_q[Q_W] ? NEG_LIM : POS_LIM;
    mq  = (ovf_q[Q_W] || (q_q[Q_W] > lim)) ? lim : q_q[Q_W];
    sq  = neg_q[Q_W] ? (Q_W'(0) - mq) : mq;
  end

  always_ff @(posedge clk_i) begin
    res_q <= zero_q[Q_W] ? '0 : sq[OUT_W-1:0];
  end

  assign res_o = res_q;

endmodule

[sv/matrix3x3_inverse_top.sv]
`timescale 1ns / 1ps
// channel   ports                         direction  handshake
// request   start_i, req_i, busy_o        in         taken when start_i && !busy_o
// result    valid_o, res_o                out        one-cycle strobe, no backpressure
//
// fully pipelined: a request may be issued every cycle, busy_o stays low
// the front registers cofactors and determinant, followed by
// one setup, one per quotient bit (33) and one saturate stage in the divider lanes
// reset clears only the valid and singular tracking, the datapath is free running
// the receiver cannot stall, a result is shown for exactly one cycle
module matrix3x3_inverse_top
  import m3i_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output res_t res_o
);

  logic                    front_vld;
  cof_t [8:0]              cof;
  det_t                    det;
  logic signed [OUT_W-1:0] lane_res [9];

  // valid and singular travel alongside the divider lanes
  logic [LANE_LAT-1:0] vpipe_q, vpipe_d;
  logic [LANE_LAT-1:0] spipe_q, spipe_d;

  // never stalls: one request per cycle
  assign busy_o = 1'b0;

  // cofactors for each lane, and the determinant shared by all lanes
  m3i_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i && !busy_o),
    .req_i  (req_i),
    .vld_o  (front_vld),
    .cof_o  (cof),
    .det_o  (det)
  );

  // one pipelined divider lane per inverse element
  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_lane u_lane (
      .clk_i (clk_i),
      .cof_i (cof[i]),
      .det_i (det),
      .res_o (lane_res[i])
    );
  end

  always_comb begin
    vpipe_d = {vpipe_q[LANE_LAT-2:0], front_vld};
    spipe_d = {spipe_q[LANE_LAT-2:0], (det == '0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q <= '0;
      spipe_q <= '0;
    end else begin
      vpipe_q <= vpipe_d;
      spipe_q <= spipe_d;
    end
  end

  // merge: lanes come out together, adjugate order is already transposed
  always_comb begin
    res_o.r00      = lane_res[0];
    res_o.r01      = lane_res[1];
    res_o.r02      = lane_res[2];
    res_o.r10      = lane_res[3];
    res_o.r11      = lane_res[4];
    res_o.r12      = lane_res[5];
    res_o.r20      = lane_res[6];
    res_o.r21      = lane_res[7];
    res_o.r22      = lane_res[8];
    res_o.singular = spipe_q[LANE_LAT-1];
  end

  assign valid_o = vpipe_q[LANE_LAT-1];

  // every accepted request comes out after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(PIPE_LAT) valid_o)
    else $error("result missing after pipeline latency");

  // no result without a request
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(start_i, PIPE_LAT))
    else $error("result without request");

  // singular matrix gives zero elements
  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.singular) |-> (res_o.r00 == '0 && res_o.r11 == '0 &&
      res_o.r22 == '0 && res_o.r01 == '0 && res_o.r12 == '0))
    else $error("singular result has nonzero elements");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import m3i_pkg::*;

  localparam int unsigned MAX_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic valid_o;
  res_t res_o;

  matrix3x3_inverse_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .req_i(req_i),
    .busy_o(busy_o),
    .valid_o(valid_o),
    .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  // requests waiting to be issued, inverses waiting to come out
  req_t pending_reqs[$];
  res_t expected_inverses[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  bit idle_allowed = 1'b1;
  bit drain_hold = 1'b0;
  bit stim_done = 1'b0;

  // truncated, saturated cof * 2^SCALE / det, det nonzero
  function automatic logic [OUT_W-1:0] scaled_quotient(longint cof, longint det);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    bit neg;
    begin
      if (cof == 0) return '0;
      neg = (cof < 0) != (det < 0);
      num = 128'(cof < 0 ? -cof : cof) << SCALE;
      den = 128'(det < 0 ? -det : det);
      quo = num / den;
      if (neg) begin
        if (quo > 128'h8000_0000) quo = 128'h8000_0000;
        return OUT_W'(-quo);
      end
      if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
      return OUT_W'(quo);
    end
  endfunction

  function automatic res_t invert_matrix(req_t m);
    longint a[9];
    longint c[9];
    longint det;
    logic [OUT_W-1:0] r[9];
    res_t o;
    begin
      a[0] = m.m00; a[1] = m.m01; a[2] = m.m02;
      a[3] = m.m10; a[4] = m.m11; a[5] = m.m12;
      a[6] = m.m20; a[7] = m.m21; a[8] = m.m22;
      // adjugate cofactors, exact
      c[0] = a[4] * a[8] - a[5] * a[7];
      c[1] = a[2] * a[7] - a[1] * a[8];
      c[2] = a[1] * a[5] - a[2] * a[4];
      c[3] = a[5] * a[6] - a[3] * a[8];
      c[4] = a[0] * a[8] - a[2] * a[6];
      c[5] = a[2] * a[3] - a[0] * a[5];
      c[6] = a[3] * a[7] - a[4] * a[6];
      c[7] = a[1] * a[6] - a[0] * a[7];
      c[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
      o = '0;
      // singular matrix: all elements zero, flag set
      if (det == 0) begin
        o.singular = 1'b1;
        return o;
      end
      for (int i = 0; i < 9; i++) r[i] = scaled_quotient(c[i], det);
      o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
      o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
      o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
      return o;
    end
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    mismatches++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
  endtask

  function automatic logic [IN_W-1:0] rand_elem(int unsigned mode);
    case (mode)
      0: return IN_W'($urandom);
      1: return IN_W'($urandom_range(0, 8)) - IN_W'(4);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return IN_W'($urandom_range(0, 8192)) - IN_W'(4096);
    endcase
  endfunction

  function automatic req_t random_matrix();
    req_t m;
    int unsigned mode;
    int unsigned kind;
    logic [IN_W-1:0] e[9];
    begin
      mode = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) e[i] = rand_elem(mode);
      if (kind == 0) begin
        // repeated row forces a zero determinant
        e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end else if (kind == 1) begin
        // near-identity scaled by a tiny factor gives very large elements
        for (int i = 0; i < 9; i++) e[i] = IN_W'($urandom_range(0, 2)) - IN_W'(1);
        e[0] = 16'd1; e[4] = 16'd1; e[8] = 16'd1;
      end
      m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      return m;
    end
  endfunction

  function automatic req_t diag(logic [IN_W-1:0] d0, logic [IN_W-1:0] d1, logic [IN_W-1:0] d2);
    req_t m;
    begin
      m = '0;
      m.m00 = d0; m.m11 = d1; m.m22 = d2;
      return m;
    end
  endfunction

  initial begin
    req_t m;
    // identity in Q3.12
    pending_reqs.push_back(diag(16'h1000, 16'h1000, 16'h1000));
    // all zero, singular
    pending_reqs.push_back('0);
    // extremes on the diagonal
    pending_reqs.push_back(diag(16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_reqs.push_back(diag(16'h8000, 16'h8000, 16'h8000));
    pending_reqs.push_back(diag(16'h8000, 16'h7FFF, 16'h8000));
    // tiny determinant of either sign
    pending_reqs.push_back(diag(16'h0001, 16'h0001, 16'h0001));
    pending_reqs.push_back(diag(16'hFFFF, 16'h0001, 16'h0001));
    // all elements equal (both extremes and minus one), singular
    pending_reqs.push_back({9{16'h7FFF}});
    pending_reqs.push_back({9{16'h8000}});
    pending_reqs.push_back({9{16'hFFFF}});
    // zero cofactors in a nonsingular matrix
    m = diag(16'h1000, 16'h2000, 16'hC000);
    m.m01 = 16'h0800;
    pending_reqs.push_back(m);
    // alternating bit patterns
    pending_reqs.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                            16'h1234, 16'hAAAA, 16'hFEDC, 16'h5555});
    pending_reqs.push_back({16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 16'hAAAA,
                            16'h5555, 16'h00FF, 16'hFF00, 16'hAAAA});
    // permutation matrix with a negative entry
    pending_reqs.push_back({16'h0, 16'hF000, 16'h0, 16'h0, 16'h0, 16'h1000,
                            16'h1000, 16'h0, 16'h0});
    for (int i = 0; i < 1536; i++) pending_reqs.push_back(random_matrix());
  end

  // driver: bursty gaps, one pause to drain, no gaps near the end
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // the head of the queue is the request on the ports; drop it once taken
      if (start_i && !busy_o) void'(pending_reqs.pop_front());
      if (pending_reqs.size() < 200) idle_allowed <= 1'b0;
      if (pending_reqs.size() == 800 && !drain_hold && expected_inverses.size() != 0) begin
        drain_hold <= 1'b1;
      end
      if (drain_hold && expected_inverses.size() == 0) drain_hold <= 1'b0;
      if (drain_hold && expected_inverses.size() != 0) begin
        start_i <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 6);
        start_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        start_i <= 1'b1;
        req_i <= pending_reqs[0];
      end else begin
        start_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor: predict on acceptance, compare each strobed result
  always @(posedge clk_i) begin
    res_t exp_res;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_inverses.push_back(invert_matrix(req_i));
      if (valid_o) begin
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected result", res_o.r00, '0);
        end else begin
          exp_res = expected_inverses.pop_front();
          if (res_o.r00 !== exp_res.r00) report_mismatch("r00", res_o.r00, exp_res.r00);
          if (res_o.r01 !== exp_res.r01) report_mismatch("r01", res_o.r01, exp_res.r01);
          if (res_o.r02 !== exp_res.r02) report_mismatch("r02", res_o.r02, exp_res.r02);
          if (res_o.r10 !== exp_res.r10) report_mismatch("r10", res_o.r10, exp_res.r10);
          if (res_o.r11 !== exp_res.r11) report_mismatch("r11", res_o.r11, exp_res.r11);
          if (res_o.r12 !== exp_res.r12) report_mismatch("r12", res_o.r12, exp_res.r12);
          if (res_o.r20 !== exp_res.r20) report_mismatch("r20", res_o.r20, exp_res.r20);
          if (res_o.r21 !== exp_res.r21) report_mismatch("r21", res_o.r21, exp_res.r21);
          if (res_o.r22 !== exp_res.r22) report_mismatch("r22", res_o.r22, exp_res.r22);
          if (res_o.singular !== exp_res.singular) begin
            report_mismatch("singular", OUT_W'(res_o.singular), OUT_W'(exp_res.singular));
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && !start_i && expected_inverses.size() == 0);
    // let any stray result show up
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_inverses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle_count >= MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
